[hw/rtl/spq_pkg.sv]
package spq_pkg;

  // operation codes on the command port
  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2
  } cmd_e;

  localparam int unsigned DefDepth       = 16;
  localparam int unsigned DefKeyBits     = 16;
  localparam int unsigned DefPayloadBits = 32;

  localparam int unsigned CapBits  = 5;
  localparam logic [CapBits-1:0] CapReset = CapBits'(10);

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic enq;  // enqueue taken: insert or shift right
    logic deq;  // dequeue taken: shift left
  } cell_ctrl_t;

endpackage

[hw/rtl/sorted_priority_queue_core.sv]
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+-------------------------------------
// command   | in        | start high, busy low          | cmd_i, entry_key_i, entry_payload_i
// result    | out       | result_valid_o, one cycle     | success_o, is_empty_o, entry_count_o,
//           |           |                               | head_key_o, head_payload_o
// config    | in        | cfg_valid_i and cfg_ready_o   | cfg_capacity_limit_i
//
// one command per cycle: busy stays low, every cell compares and shifts in the same cycle
// the result of a command is shown in the cycle after its transaction, for one cycle only
// the result is registered, in the cell registers and the result strobe register
// reset clears the count, the strobe and sets the capacity limit to ten; cell contents
// are not reset, cells at or above the count are never shown
// the receiver cannot stall: a result not taken in its cycle is gone
module sorted_priority_queue_core #(
  parameter int unsigned Depth       = spq_pkg::DefDepth,
  parameter int unsigned KeyBits     = spq_pkg::DefKeyBits,
  parameter int unsigned PayloadBits = spq_pkg::DefPayloadBits,
  localparam int unsigned CntBits    = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd_i,
  input  logic [KeyBits-1:0]          entry_key_i,
  input  logic [PayloadBits-1:0]      entry_payload_i,
  // result channel
  output logic                        result_valid_o,
  output logic                        success_o,
  output logic                        is_empty_o,
  output logic [CntBits-1:0]          entry_count_o,
  output logic [KeyBits-1:0]          head_key_o,
  output logic [PayloadBits-1:0]      head_payload_o,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spq_pkg::CapBits-1:0] cfg_capacity_limit_i
);
  import spq_pkg::*;

  // common width for comparing the count against the 5-bit limit
  localparam int unsigned CmpBits = (CntBits > CapBits) ? CntBits : CapBits;
  localparam logic [CmpBits-1:0] DepthCmp = CmpBits'(Depth);

  logic                   accept;
  logic                   full, empty;
  logic                   enq_ok, deq_ok, peek_ok;
  cell_ctrl_t             ctrl;

  logic [CntBits-1:0]     count_q, count_d;
  logic [CapBits-1:0]     cap_q;
  logic                   result_valid_q;
  logic                   success_q, success_d;

  logic [Depth-1:0]       occupied;
  logic [Depth-1:0]       gt_w;
  logic [KeyBits-1:0]     key_w     [Depth];
  logic [PayloadBits-1:0] payload_w [Depth];

  // every cell updates in the accept cycle, so a new command can follow at once
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // full when the count reaches the programmed limit or the number of cells
  assign full  = (CmpBits'(count_q) >= CmpBits'(cap_q)) || (CmpBits'(count_q) >= DepthCmp);
  assign empty = (count_q == '0);

  assign enq_ok  = accept && (cmd_i == CMD_ENQUEUE) && !full;
  assign deq_ok  = accept && (cmd_i == CMD_DEQUEUE) && !empty;
  assign peek_ok = accept && (cmd_i == CMD_PEEK) && !empty;

  assign ctrl.enq = enq_ok;
  assign ctrl.deq = deq_ok;

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntBits'(1);
    end else if (deq_ok) begin
      count_d = count_q - CntBits'(1);
    end
  end

  assign success_d = enq_ok || deq_ok || peek_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
      success_q      <= 1'b0;
    end else begin
      count_q        <= count_d;
      result_valid_q <= accept;
      success_q      <= success_d;
    end
  end

  // configuration: always ready; the user must write only while the queue is quiet, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_limit_i;
    end
  end

  // row of cells, slot 0 is the head; data moves right on insert, left on removal
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                   left_gt;
    logic [KeyBits-1:0]     left_key, right_key;
    logic [PayloadBits-1:0] left_payload, right_payload;

    assign occupied[i] = (CmpBits'(i) < CmpBits'(count_q));

    if (i == 0) begin : g_first
      assign left_gt      = 1'b0;
      assign left_key     = '0;
      assign left_payload = '0;
    end else begin : g_inner_left
      assign left_gt      = gt_w[i-1];
      assign left_key     = key_w[i-1];
      assign left_payload = payload_w[i-1];
    end

    if (i == Depth - 1) begin : g_last
      // nothing to pull in from the right, the last slot just holds
      assign right_key     = key_w[i];
      assign right_payload = payload_w[i];
    end else begin : g_inner_right
      assign right_key     = key_w[i+1];
      assign right_payload = payload_w[i+1];
    end

    spq_cell #(
      .KeyBits     (KeyBits),
      .PayloadBits (PayloadBits)
    ) u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .occupied_i      (occupied[i]),
      .new_key_i       (entry_key_i),
      .new_payload_i   (entry_payload_i),
      .left_gt_i       (left_gt),
      .left_key_i      (left_key),
      .left_payload_i  (left_payload),
      .right_key_i     (right_key),
      .right_payload_i (right_payload),
      .gt_o            (gt_w[i]),
      .key_o           (key_w[i]),
      .payload_o       (payload_w[i])
    );
  end

  // result shows the state left by the command, head reads as zero when empty
  assign result_valid_o = result_valid_q;
  assign success_o      = success_q;
  assign is_empty_o     = empty;
  assign entry_count_o  = count_q;
  assign head_key_o     = empty ? '0 : key_w[0];
  assign head_payload_o = empty ? '0 : payload_w[0];

`ifndef SYNTHESIS
  a_strobe_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("result strobe missing after accepted command");

  a_no_spurious_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result strobe without accepted command");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpBits'(count_q) <= DepthCmp)
    else $error("entry count above number of cells");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_ok |=> (count_q == $past(count_q) + CntBits'(1)) && success_o)
    else $error("accepted enqueue did not grow the queue");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !success_d |=> count_q == $past(count_q))
    else $error("refused command changed the count");
`endif

endmodule

[hw/rtl/spq_cell.sv]
module spq_cell #(
  parameter int unsigned KeyBits     = 16,
  parameter int unsigned PayloadBits = 32
) (
  input  logic                    clk_i,
  input  spq_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    occupied_i,
  input  logic [KeyBits-1:0]      new_key_i,
  input  logic [PayloadBits-1:0]  new_payload_i,
  input  logic                    left_gt_i,
  input  logic [KeyBits-1:0]      left_key_i,
  input  logic [PayloadBits-1:0]  left_payload_i,
  input  logic [KeyBits-1:0]      right_key_i,
  input  logic [PayloadBits-1:0]  right_payload_i,
  output logic                    gt_o,
  output logic [KeyBits-1:0]      key_o,
  output logic [PayloadBits-1:0]  payload_o
);
  import spq_pkg::*;

  logic [KeyBits-1:0]     key_q, key_d;
  logic [PayloadBits-1:0] payload_q, payload_d;

  // held entry leaves for the new one when the new key is strictly smaller
  assign gt_o = occupied_i && (new_key_i < key_q);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.enq) begin
      if (left_gt_i) begin
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end else if (gt_o || !occupied_i) begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end else if (ctrl_i.deq) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

[tb/sv/tb_sorted_priority_queue_core.sv]
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int unsigned Depth      = DefDepth;
  localparam int unsigned KeyW       = DefKeyBits;
  localparam int unsigned PayloadW   = DefPayloadBits;
  localparam int unsigned CntW       = $clog2(DefDepth + 1);
  // the fourth command code has no operation behind it
  localparam logic [1:0]  CmdUnused  = 2'd3;
  // cycles without any transaction before the run is declared hung
  localparam int unsigned StallLimit = 2000;

  typedef logic [KeyW-1:0]     key_t;
  typedef logic [PayloadW-1:0] payload_t;

  // what every command reports back
  typedef struct packed {
    logic            success;
    logic            is_empty;
    logic [CntW-1:0] count;
    key_t            head_key;
    payload_t        head_payload;
  } queue_status_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [1:0]           cmd_i;
  key_t                 entry_key_i;
  payload_t             entry_payload_i;
  logic                 result_valid_o;
  logic                 success_o;
  logic                 is_empty_o;
  logic [CntW-1:0]      entry_count_o;
  key_t                 head_key_o;
  payload_t             head_payload_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CapBits-1:0]   cfg_capacity_limit_i;

  // shadow copy of the queue, kept sorted with slot 0 as the head
  key_t                 shadow_keys [Depth];
  payload_t             shadow_payloads [Depth];
  int unsigned          shadow_count;
  int unsigned          shadow_limit;

  queue_status_t        pending_status[$];
  int unsigned          mismatch_count;
  int unsigned          stall_cycles;
  // chance in percent that the command side idles before a command, set for each phase of the random traffic
  int unsigned          idle_pct;

  sorted_priority_queue_core DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .cmd_i                (cmd_i),
    .entry_key_i          (entry_key_i),
    .entry_payload_i      (entry_payload_i),
    .result_valid_o       (result_valid_o),
    .success_o            (success_o),
    .is_empty_o           (is_empty_o),
    .entry_count_o        (entry_count_o),
    .head_key_o           (head_key_o),
    .head_payload_o       (head_payload_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_capacity_limit_i (cfg_capacity_limit_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // capacity register capped at the physical depth
  function automatic int unsigned limit_in_force();
    return (shadow_limit > Depth) ? Depth : shadow_limit;
  endfunction

  // applies one command to the shadow queue and returns the status it reports
  function automatic queue_status_t apply_queue_op(logic [1:0] op, key_t key, payload_t payload);
    int unsigned   pos;
    logic          done;
    queue_status_t st;
    done = 1'b0;
    case (op)
      CMD_ENQUEUE: begin
        if (shadow_count < limit_in_force()) begin
          // insert behind every entry with a smaller or equal key
          pos = shadow_count;
          while (pos > 0 && key < shadow_keys[pos-1]) begin
            shadow_keys[pos]     = shadow_keys[pos-1];
            shadow_payloads[pos] = shadow_payloads[pos-1];
            pos--;
          end
          shadow_keys[pos]     = key;
          shadow_payloads[pos] = payload;
          shadow_count++;
          done = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (shadow_count != 0) begin
          for (int unsigned i = 0; i + 1 < shadow_count; i++) begin
            shadow_keys[i]     = shadow_keys[i+1];
            shadow_payloads[i] = shadow_payloads[i+1];
          end
          shadow_count--;
          done = 1'b1;
        end
      end
      CMD_PEEK: done = (shadow_count != 0);
      default: done = 1'b0;
    endcase
    st.success      = done;
    st.is_empty     = (shadow_count == 0);
    st.count        = CntW'(shadow_count);
    st.head_key     = (shadow_count != 0) ? shadow_keys[0] : '0;
    st.head_payload = (shadow_count != 0) ? shadow_payloads[0] : '0;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // one command transaction; start stays high afterwards so back-to-back
  // commands need no gap
  task automatic issue_command(input logic [1:0] op, input key_t key, input payload_t payload);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start           = 1'b1;
    cmd_i           = op;
    entry_key_i     = key;
    entry_payload_i = payload;
    do @(posedge clk_i); while (busy);
    pending_status.push_back(apply_queue_op(op, key, payload));
  endtask

  // drops start and waits until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    // margin after the last result has been checked
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i          = 1'b1;
    cfg_capacity_limit_i = CapBits'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_limit = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // dequeue and peek on the queue right after reset
  task automatic test_empty_queue();
    issue_command(CMD_DEQUEUE, '0, '0);
    issue_command(CMD_PEEK, '0, '0);
  endtask

  // fill to the reset limit of ten with extreme and equal keys, one refused enqueue, then an unused code and a peek
  task automatic test_fill_to_limit();
    key_t     keys [11];
    payload_t pays [11];
    keys = '{16'hFFFF, 16'h0000, 16'd5, 16'd5, 16'd5, 16'h8000, 16'd3, 16'd5,
             16'hFFFF, 16'h0000, 16'd1};
    pays = '{32'hFFFF_FFFF, 32'h0, 32'hA, 32'hB, 32'hC, 32'h5555_AAAA, 32'hAAAA_5555,
             32'hD, 32'h1234_5678, 32'h8000_0001, 32'hE};
    for (int i = 0; i < 11; i++) issue_command(CMD_ENQUEUE, keys[i], pays[i]);
    issue_command(CmdUnused, 16'h1234, 32'h1);
    issue_command(CMD_PEEK, '0, '0);
  endtask

  // a zero limit refuses enqueue even with entries held
  task automatic test_zero_limit();
    write_capacity(0);
    issue_command(CMD_ENQUEUE, 16'd7, 32'h7);
  endtask

  // limit lowered below the held count: entries stay, enqueue is refused until the count drops below the limit
  task automatic test_limit_below_count();
    write_capacity(3);
    issue_command(CMD_ENQUEUE, 16'd2, 32'h2);
    repeat (8) issue_command(CMD_DEQUEUE, '0, '0);
    issue_command(CMD_ENQUEUE, 16'd4, 32'h4);
    issue_command(CMD_ENQUEUE, 16'd4, 32'h5);
  endtask

  // fill and drain bursts with random content over several limits and idle rates
  task automatic test_random_traffic();
    int unsigned limits [7];
    int unsigned pcts [3];
    int unsigned r;
    bit          filling;
    logic [1:0]  op;
    key_t        key;
    payload_t    pay;
    limits  = '{16, 2, 16, 1, 10, 5, 16};
    pcts    = '{0, 82, 13};
    filling = 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      write_capacity(limits[ph]);
      idle_pct = pcts[ph % 3];
      repeat (160) begin
        if (shadow_count >= limit_in_force()) filling = 1'b0;
        else if (shadow_count == 0) filling = 1'b1;
        else if ($urandom_range(31) == 0) filling = !filling;
        r = $urandom_range(99);
        if (filling) begin
          op = (r < 72) ? CMD_ENQUEUE : (r < 88) ? CMD_DEQUEUE : (r < 98) ? CMD_PEEK : CmdUnused;
        end else begin
          op = (r < 22) ? CMD_ENQUEUE : (r < 85) ? CMD_DEQUEUE : (r < 98) ? CMD_PEEK : CmdUnused;
        end
        // narrow keys often, so equal keys meet and order by arrival
        r = $urandom_range(9);
        if (r < 4) key = key_t'($urandom_range(7));
        else if (r == 4) key = $urandom_range(1) ? '1 : '0;
        else key = key_t'($urandom);
        r = $urandom_range(9);
        if (r == 0) pay = $urandom_range(1) ? '1 : '0;
        else pay = payload_t'($urandom);
        issue_command(op, key, pay);
      end
    end
    idle_pct = 0;
  endtask

  // result checker: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    queue_status_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result without command", 64'(success_o), 64'(0));
      end else begin
        want = pending_status.pop_front();
        if (success_o !== want.success)
          report_mismatch("success", 64'(success_o), 64'(want.success));
        if (is_empty_o !== want.is_empty)
          report_mismatch("is_empty", 64'(is_empty_o), 64'(want.is_empty));
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", 64'(entry_count_o), 64'(want.count));
        if (head_key_o !== want.head_key)
          report_mismatch("head_key", 64'(head_key_o), 64'(want.head_key));
        if (head_payload_o !== want.head_payload)
          report_mismatch("head_payload", 64'(head_payload_o), 64'(want.head_payload));
      end
    end
  end

  // watchdog: counts cycles in which no transaction of any kind happens
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    start                = 1'b0;
    cmd_i                = CMD_PEEK;
    entry_key_i          = '0;
    entry_payload_i      = '0;
    cfg_valid_i          = 1'b0;
    cfg_capacity_limit_i = CapReset;
    shadow_count         = 0;
    shadow_limit         = 32'(CapReset);
    mismatch_count       = 0;
    stall_cycles         = 0;
    idle_pct             = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_fill_to_limit();
    test_zero_limit();
    test_limit_below_count();
    test_random_traffic();

    wait_drained();
    repeat (3) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
tb/sv/tb_sorted_priority_queue_core.sv
